// File: rtl/rv32i_instruction_step_macros.svh
// assertion macros shared by the rv32i step core
`ifndef RV32I_INSTRUCTION_STEP_MACROS_SVH
`define RV32I_INSTRUCTION_STEP_MACROS_SVH

// property checked on every clock edge outside reset
`define RV32I_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked on every clock edge outside reset
`define RV32I_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/rv32i_pkg.sv
package rv32i_pkg;

    // major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // alu funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // load / store funct3
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SW  = 3'd2;
    localparam logic [2:0] F3_PRIV = 3'd0;
    localparam logic [2:0] F3_SYS_BAD = 3'd4;
    localparam logic [2:0] F3_FENCE_I = 3'd1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_RANGE   = 2'd2,
        ST_LOADED  = 2'd3
    } t_status;

    // result transaction, first field in the high bits
    typedef struct packed {
        t_status     status;
        logic        dest_written;
        logic [31:0] dest_value;
        logic [4:0]  dest_index;
        logic [31:0] instr_word;
        logic [31:0] pc_after;
    } t_result;

endpackage

// File: rtl/rv32i_instruction_step.sv
// RV32I step core. Each input transaction either writes one little-endian word into
// the byte memory (tuser = 1) or executes the instruction at the PC (tuser = 0) and
// returns one result transaction. A memory write and a fetch out of range finish
// in the idle state; an instruction passes through fetch from the byte-lane memory,
// register file read and execute, and a load adds a data-access state, since
// fetch and data access share the four byte-lane RAMs. One item is in flight at a
// time; the next one is taken once the previous result leaves the output register,
// at the earliest in the same cycle. MEM_BYTES must be a power of two.
`include "rv32i_instruction_step_macros.svh"

module rv32i_instruction_step #(
    parameter int MEM_BYTES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // mem_addr[11:0], mem_data[43:12], zero pad
    input  logic [0:0]   i_s_tuser,   // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // pc_after, instr_word, dest_index, dest_value, dest_written, status
    output logic [103:0] o_m_tdata
);
    import rv32i_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / 4;
    localparam logic [32:0] MEM_END = 33'(MEM_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_LOAD} t_state;

    t_state      r_state;
    logic [31:0] r_pc;
    logic [31:0] r_ins;
    logic [1:0]  r_lo;
    logic        r_out_valid;
    t_result     r_out;
    logic [31:0] r_rf_vld;

    logic        in_acc, in_wr;
    logic [11:0] in_addr;
    logic [31:0] in_data;
    logic [31:0] acc_addr, acc_data;
    logic [2:0]  acc_n;
    logic        acc_we;
    logic [7:0]  bank_rd [4];
    logic [31:0] fetched;
    logic [31:0] rf1_rd, rf2_rd, rs1v, rs2v;
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd, sh;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, alu_b, alu_res, ls_addr;
    logic        alu_bad, ls_ok, take;
    logic [2:0]  ls_n;
    logic [31:0] ex_val, ex_next, ld_val;
    logic        ex_wr, ex_load, ex_store;
    t_status     ex_status;
    logic        fin, fin_wr, rf_we;
    logic [31:0] fin_val, fin_next;
    t_status     fin_status;

    function automatic logic in_rng(logic [31:0] a, logic [2:0] n);
        return ({1'b0, a} + 33'(n)) <= MEM_END;
    endfunction

    // input transaction
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign in_wr      = i_s_tuser[0];
    assign in_addr    = i_s_tdata[11:0];
    assign in_data    = i_s_tdata[43:12];

    // decode fields
    assign opc   = r_ins[6:0];
    assign rd    = r_ins[11:7];
    assign f3    = r_ins[14:12];
    assign f7    = r_ins[31:25];
    assign imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign imm_j = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};
    assign imm_u = {r_ins[31:12], 12'b0};

    // register operands, unwritten entries read as zero
    assign rs1v = r_rf_vld[r_ins[19:15]] ? rf1_rd : 32'd0;
    assign rs2v = r_rf_vld[r_ins[24:20]] ? rf2_rd : 32'd0;

    // alu
    assign alu_b = (opc == OP_REG) ? rs2v : imm_i;
    assign sh    = (opc == OP_REG) ? rs2v[4:0] : r_ins[24:20];
    always_comb begin
        case (f3)
            F3_ADD:  alu_res = (opc == OP_REG && f7 == F7_ALT) ? rs1v - alu_b : rs1v + alu_b;
            F3_SLL:  alu_res = rs1v << sh;
            F3_SLT:  alu_res = {31'd0, $signed(rs1v) < $signed(alu_b)};
            F3_SLTU: alu_res = {31'd0, rs1v < alu_b};
            F3_XOR:  alu_res = rs1v ^ alu_b;
            F3_SR:   alu_res = (f7 == F7_ALT) ? 32'($signed(rs1v) >>> sh) : rs1v >> sh;
            F3_OR:   alu_res = rs1v | alu_b;
            default: alu_res = rs1v & alu_b;
        endcase
    end
    assign alu_bad = (f3 == F3_SR || (f3 == F3_ADD && opc == OP_REG))
                     && f7 != F7_BASE && f7 != F7_ALT;

    // load / store address
    assign ls_addr = rs1v + ((opc == OP_STORE) ? imm_s : imm_i);
    assign ls_n    = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
    assign ls_ok   = in_rng(ls_addr, ls_n);

    // branch condition
    always_comb begin
        case (f3)
            F3_BEQ:  take = rs1v == rs2v;
            F3_BNE:  take = rs1v != rs2v;
            F3_BLT:  take = $signed(rs1v) < $signed(rs2v);
            F3_BGE:  take = $signed(rs1v) >= $signed(rs2v);
            F3_BLTU: take = rs1v < rs2v;
            F3_BGEU: take = rs1v >= rs2v;
            default: take = 1'b0;
        endcase
    end

    // execute
    always_comb begin
        ex_val    = 32'd0;
        ex_wr     = 1'b0;
        ex_next   = r_pc + 32'd4;
        ex_status = ST_OK;
        ex_load   = 1'b0;
        ex_store  = 1'b0;
        unique case (opc) inside
            OP_LUI: begin
                ex_val = imm_u;
                ex_wr  = 1'b1;
            end
            OP_AUIPC: begin
                ex_val = r_pc + imm_u;
                ex_wr  = 1'b1;
            end
            OP_JAL: begin
                ex_val  = r_pc + 32'd4;
                ex_wr   = 1'b1;
                ex_next = r_pc + imm_j;
            end
            OP_JALR: begin
                ex_val  = r_pc + 32'd4;
                ex_wr   = 1'b1;
                ex_next = (rs1v + imm_i) & ~32'd1;
            end
            OP_BRANCH: begin
                if (f3 == 3'd2 || f3 == 3'd3) begin
                    ex_status = ST_ILLEGAL;
                end else if (take) begin
                    ex_next = r_pc + imm_b;
                end
            end
            OP_LOAD: begin
                if (f3 == 3'd3 || f3 > F3_LHU) begin
                    ex_status = ST_ILLEGAL;
                end else begin
                    ex_wr = 1'b1;
                    if (!ls_ok) begin
                        ex_status = ST_RANGE;
                    end else begin
                        ex_load = 1'b1;
                    end
                end
            end
            OP_STORE: begin
                if (f3 > F3_SW) begin
                    ex_status = ST_ILLEGAL;
                end else if (!ls_ok) begin
                    ex_status = ST_RANGE;
                end else begin
                    ex_store = 1'b1;
                end
            end
            OP_IMM, OP_REG: begin
                if (alu_bad) begin
                    ex_status = ST_ILLEGAL;
                end else begin
                    ex_val = alu_res;
                    ex_wr  = 1'b1;
                end
            end
            OP_FENCE: begin
                if (f3 > F3_FENCE_I) ex_status = ST_ILLEGAL;
            end
            OP_SYSTEM: begin
                if (f3 == F3_SYS_BAD || (f3 == F3_PRIV && r_ins[31:20] > 12'd1)) begin
                    ex_status = ST_ILLEGAL;
                end
            end
            default: ex_status = ST_ILLEGAL;
        endcase
    end

    // byte-lane access select: fetch or word write when idle, data access in execute
    always_comb begin
        if (r_state == S_EXEC) begin
            acc_addr = ls_addr;
            acc_n    = ls_n;
            acc_data = rs2v;
            acc_we   = ex_store;
        end else begin
            acc_addr = in_wr ? 32'(in_addr) : r_pc;
            acc_n    = 3'd4;
            acc_data = in_data;
            acc_we   = (r_state == S_IDLE) && in_acc && in_wr && in_rng(32'(in_addr), 3'd4);
        end
    end

    // four byte lanes, lane k holds bytes whose address is k modulo 4
    for (genvar b = 0; b < 4; b++) begin : g_lane
        logic [1:0]    lane;
        logic [AW-1:0] sum;
        assign lane = 2'(b) - acc_addr[1:0];
        assign sum  = acc_addr[AW-1:0] + AW'(lane);
        rv32i_ram #(.W(8), .D(ROWS)) u_lane (
            .i_clk   (i_clk),
            .i_we    (acc_we && (3'(lane) < acc_n)),
            .i_waddr (sum[AW-1:2]),
            .i_wdata (acc_data[{lane, 3'b000} +: 8]),
            .i_raddr (sum[AW-1:2]),
            .o_rdata (bank_rd[b])
        );
    end

    // reassemble bytes in address order
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fetched[8*i +: 8] = bank_rd[2'(i) + r_lo];
        end
    end

    // load extension
    always_comb begin
        case (f3)
            F3_LB:   ld_val = {{24{fetched[7]}}, fetched[7:0]};
            F3_LH:   ld_val = {{16{fetched[15]}}, fetched[15:0]};
            F3_LBU:  ld_val = {24'd0, fetched[7:0]};
            F3_LHU:  ld_val = {16'd0, fetched[15:0]};
            default: ld_val = fetched;
        endcase
    end

    // completion of an instruction
    assign fin        = (r_state == S_EXEC && !ex_load) || r_state == S_LOAD;
    assign fin_val    = (r_state == S_LOAD) ? ld_val : ex_val;
    assign fin_wr     = (r_state == S_LOAD) ? 1'b1 : ex_wr;
    assign fin_next   = (r_state == S_LOAD) ? r_pc + 32'd4 : ex_next;
    assign fin_status = (r_state == S_LOAD) ? ST_OK : ex_status;
    assign rf_we      = fin && fin_wr && rd != 5'd0;

    // register file, two copies for two read ports
    rv32i_ram #(.W(32), .D(32)) u_rf1 (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rd),
        .i_wdata (fin_val),
        .i_raddr (fetched[19:15]),
        .o_rdata (rf1_rd)
    );
    rv32i_ram #(.W(32), .D(32)) u_rf2 (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rd),
        .i_wdata (fin_val),
        .i_raddr (fetched[24:20]),
        .o_rdata (rf2_rd)
    );

    // sequencer, pc and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= 32'd0;
            r_out_valid <= 1'b0;
            r_rf_vld    <= 32'd0;
        end else begin
            if (r_out_valid && i_m_tready && !in_acc) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_lo <= acc_addr[1:0];
                        r_out.instr_word   <= 32'd0;
                        r_out.dest_index   <= 5'd0;
                        r_out.dest_value   <= 32'd0;
                        r_out.dest_written <= 1'b0;
                        if (in_wr) begin
                            r_out_valid    <= 1'b1;
                            r_out.pc_after <= r_pc;
                            r_out.status   <= in_rng(32'(in_addr), 3'd4) ? ST_LOADED : ST_RANGE;
                        end else if (!in_rng(r_pc, 3'd4)) begin
                            r_out_valid    <= 1'b1;
                            r_out.pc_after <= r_pc + 32'd4;
                            r_out.status   <= ST_RANGE;
                            r_pc           <= r_pc + 32'd4;
                        end else begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_ins   <= fetched;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (ex_load) begin
                        r_lo    <= ls_addr[1:0];
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // completion below returns to idle
                end
                default: r_state <= S_IDLE;
            endcase
            if (fin) begin
                r_state            <= S_IDLE;
                r_pc               <= fin_next;
                r_out_valid        <= 1'b1;
                r_out.pc_after     <= fin_next;
                r_out.instr_word   <= r_ins;
                r_out.dest_index   <= rf_we ? rd : 5'd0;
                r_out.dest_value   <= rf_we ? fin_val : 32'd0;
                r_out.dest_written <= rf_we;
                r_out.status       <= fin_status;
                if (rf_we) r_rf_vld[rd] <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // checks
    `RV32I_ASSERT_IMP(a_busy_blocks_input, r_state != S_IDLE, !o_s_tready, "input taken while busy")
    `RV32I_ASSERT_IMP(a_dest_nonzero, o_m_tvalid && r_out.dest_written, r_out.dest_index != 5'd0, "x0 reported written")
    `RV32I_ASSERT(a_x0_never_valid, !r_rf_vld[0], "x0 marked written")
    `RV32I_ASSERT_IMP(a_load_after_exec, r_state == S_LOAD, $past(r_state) == S_EXEC, "load state entered out of order")

endmodule

// File: rtl/rv32i_ram.sv
module rv32i_ram #(
    parameter int W = 8,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] mem [D];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
